FILE: rtl/lfs_pkg.sv
package lfs_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CLUSTERS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FIRST_CLUSTER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WANT_FRAGMENTED   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_BYTES     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [31:0] TARGET_CLUSTERS_RST   = 32'd0;
    localparam logic [27:0] MIN_FIRST_CLUSTER_RST = 28'd2;
    localparam logic        WANT_FRAGMENTED_RST   = 1'b0;
    localparam logic [20:0] CLUSTER_BYTES_RST     = 21'd512;

    // Command codes carried in the command field of an input transaction.
    localparam logic CMD_NEW_SEARCH  = 1'b0;
    localparam logic CMD_OFFER_ENTRY = 1'b1;

    // Attribute byte bits that make an entry ineligible.
    localparam int ATTR_HIDDEN_BIT = 1;
    localparam int ATTR_SYSTEM_BIT = 2;

    // Bit-serial divider geometry: one quotient bit per cycle.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;
    localparam int DIVISOR_W = 21;
    localparam int REM_W     = DIVISOR_W + 1;

    // Job queue geometry.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic        command;
        logic        is_long_name;
        logic [7:0]  attribute;
        logic [27:0] first_cluster;
        logic [31:0] file_size;
        logic        is_fragmented;
        logic        read_error;
        logic [31:0] entry_position;
    } in_t;

    typedef struct packed {
        logic [31:0] found_clusters;
        logic [31:0] found_position;
        logic        found_valid;
        logic        search_done;
        logic        search_error;
    } out_t;

    typedef struct packed {
        logic [31:0] target_clusters;
        logic [27:0] min_first_cluster;
        logic        want_fragmented;
        logic [20:0] cluster_bytes;
    } cfg_t;

    // What the back end has to do with one transaction.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ERROR = 2'd1,
        OP_SKIP  = 2'd2,
        OP_CAND  = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] count;
        logic [31:0] position;
    } job_t;

endpackage

FILE: rtl/lfs_front.sv
module lfs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  lfs_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  lfs_pkg::in_t  s_data,
    output logic          job_valid,
    input  logic          job_ready,
    output lfs_pkg::job_t job_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t                        state_reg, state_next;
    lfs_pkg::op_t                        op_reg, op_next;
    logic [31:0]                         pos_reg, pos_next;
    logic [31:0]                         quot_reg, quot_next;
    logic [lfs_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic [lfs_pkg::DIVISOR_W-1:0]       div_reg, div_next;
    logic [lfs_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;

    logic                                accept;
    logic                                skip;
    lfs_pkg::op_t                        op_in;
    logic [lfs_pkg::REM_W-1:0]           rem_shift;
    logic                                q_bit;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;

    // Classify the incoming transaction against the eligibility rules.
    always_comb begin
        skip = s_data.is_long_name
            || s_data.attribute[lfs_pkg::ATTR_HIDDEN_BIT]
            || s_data.attribute[lfs_pkg::ATTR_SYSTEM_BIT]
            || (s_data.first_cluster < cfg.min_first_cluster)
            || (s_data.is_fragmented != cfg.want_fragmented);
        if (s_data.command == lfs_pkg::CMD_NEW_SEARCH) begin
            op_in = lfs_pkg::OP_CLEAR;
        end else if (s_data.read_error) begin
            op_in = lfs_pkg::OP_ERROR;
        end else if (skip) begin
            op_in = lfs_pkg::OP_SKIP;
        end else begin
            op_in = lfs_pkg::OP_CAND;
        end
    end

    // One restoring division step: the quotient shifts into the dividend register.
    always_comb begin
        rem_shift = {rem_reg[lfs_pkg::REM_W-2:0], quot_reg[31]};
        q_bit     = (rem_shift >= {1'b0, div_reg});
    end

    // Sequencer for accept, divide and hand-off.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    op_next   = op_in;
                    pos_next  = s_data.entry_position;
                    quot_next = s_data.file_size;
                    rem_next  = '0;
                    // A cluster size of zero behaves as one byte.
                    div_next  = (cfg.cluster_bytes == '0) ?
                                lfs_pkg::DIVISOR_W'(1) : cfg.cluster_bytes;
                    cnt_next  = '0;
                    state_next = (op_in == lfs_pkg::OP_CAND) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                rem_next  = q_bit ? (rem_shift - {1'b0, div_reg}) : rem_shift;
                quot_next = {quot_reg[30:0], q_bit};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == lfs_pkg::DIV_CNT_W'(lfs_pkg::DIV_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (job_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Round the quotient up when a remainder is left.
    assign job_valid         = (state_reg == F_PUSH);
    assign job_data.op       = op_reg;
    assign job_data.count    = quot_reg + {31'd0, (rem_reg != '0)};
    assign job_data.position = pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        cnt_reg  <= cnt_next;
    end

`ifndef SYNTH
    // The remainder of a restoring division always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV || state_reg == F_PUSH) |-> (rem_reg < {1'b0, div_reg}))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: rtl/lfs_queue.sv
module lfs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  lfs_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output lfs_pkg::job_t pop_data
);

    lfs_pkg::job_t                     mem_reg [lfs_pkg::QUEUE_DEPTH];
    logic [lfs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lfs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lfs_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != lfs_pkg::QUEUE_CNT_W'(lfs_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    // Occupancy never exceeds the depth.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lfs_pkg::QUEUE_CNT_W'(lfs_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");
    // Pointers agree whenever the queue is empty or full.
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == lfs_pkg::QUEUE_CNT_W'(lfs_pkg::QUEUE_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

FILE: rtl/lfs_back.sv
module lfs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   target_clusters,
    input  logic          job_valid,
    output logic          job_ready,
    input  lfs_pkg::job_t job_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lfs_pkg::out_t m_data
);

    logic [31:0]   best_clusters_reg, best_clusters_next;
    logic [31:0]   best_position_reg, best_position_next;
    logic          best_valid_reg, best_valid_next;
    logic          done_reg, done_next;
    logic          error_reg, error_next;
    logic          m_valid_reg, m_valid_next;
    lfs_pkg::out_t m_data_reg, m_data_next;
    logic          take;

    // A job is taken when the output register is free or being emptied.
    assign job_ready = !m_valid_reg || m_ready;
    assign take      = job_valid && job_ready;

    // Search state update for one job.
    always_comb begin
        best_clusters_next = best_clusters_reg;
        best_position_next = best_position_reg;
        best_valid_next    = best_valid_reg;
        done_next          = done_reg;
        error_next         = error_reg;
        if (take) begin
            case (job_data.op)
                lfs_pkg::OP_CLEAR: begin
                    best_clusters_next = '0;
                    best_position_next = '0;
                    best_valid_next    = 1'b0;
                    done_next          = 1'b0;
                    error_next         = 1'b0;
                end
                lfs_pkg::OP_ERROR: begin
                    if (!done_reg) begin
                        done_next  = 1'b1;
                        error_next = 1'b1;
                    end
                end
                lfs_pkg::OP_CAND: begin
                    if (!done_reg) begin
                        if (job_data.count == target_clusters) begin
                            best_clusters_next = job_data.count;
                            best_position_next = job_data.position;
                            best_valid_next    = 1'b1;
                            done_next          = 1'b1;
                        end else if (job_data.count > best_clusters_reg &&
                                     job_data.count < target_clusters) begin
                            best_clusters_next = job_data.count;
                            best_position_next = job_data.position;
                            best_valid_next    = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register shows the state after each job.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (take) begin
            m_valid_next               = 1'b1;
            m_data_next.found_clusters = best_clusters_next;
            m_data_next.found_position = best_position_next;
            m_data_next.found_valid    = best_valid_next;
            m_data_next.search_done    = done_next;
            m_data_next.search_error   = error_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_clusters_reg <= '0;
            best_position_reg <= '0;
            best_valid_reg    <= 1'b0;
            done_reg          <= 1'b0;
            error_reg         <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            best_clusters_reg <= best_clusters_next;
            best_position_reg <= best_position_next;
            best_valid_reg    <= best_valid_next;
            done_reg          <= done_next;
            error_reg         <= error_next;
            m_valid_reg       <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    // An error always finishes the search.
    a_error_implies_done: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |-> done_reg)
        else $error("search error without search done");
    // Without a chosen file the best count and position stay zero.
    a_empty_best_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !best_valid_reg |-> (best_clusters_reg == '0 && best_position_reg == '0))
        else $error("best file fields nonzero while none chosen");
    // A finished search only changes on a new search.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !(take && job_data.op == lfs_pkg::OP_CLEAR))
        |=> ($stable(best_clusters_reg) && $stable(best_position_reg) && done_reg))
        else $error("finished search state changed");
`endif

endmodule

FILE: rtl/largest_fitting_file_select_top.sv
// Path: the front end registers each accepted transaction and, for an eligible entry, runs the
// 32-step bit-serial cluster divider; the job then passes through the queue to the output register.
// Flow: the front end takes no new transaction until it has handed the last one to the queue;
// a 2-deep job queue lets the divider run while output waits.
// Reset: synchronous active-low aresetn clears the search state, the queue and the handshakes
// and loads the configuration defaults; no clearing pass is needed.
module largest_fitting_file_select_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lfs_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lfs_pkg::out_t                      m_data
);

    lfs_pkg::cfg_t cfg_reg, cfg_next;
    logic          fq_valid, fq_ready;
    lfs_pkg::job_t fq_data;
    logic          qb_valid, qb_ready;
    lfs_pkg::job_t qb_data;

    // Configuration register file.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lfs_pkg::REG_TARGET_CLUSTERS:   cfg_next.target_clusters   = cfg_wdata[31:0];
                lfs_pkg::REG_MIN_FIRST_CLUSTER: cfg_next.min_first_cluster = cfg_wdata[27:0];
                lfs_pkg::REG_WANT_FRAGMENTED:   cfg_next.want_fragmented   = cfg_wdata[0];
                lfs_pkg::REG_CLUSTER_BYTES:     cfg_next.cluster_bytes     = cfg_wdata[20:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_clusters   <= lfs_pkg::TARGET_CLUSTERS_RST;
            cfg_reg.min_first_cluster <= lfs_pkg::MIN_FIRST_CLUSTER_RST;
            cfg_reg.want_fragmented   <= lfs_pkg::WANT_FRAGMENTED_RST;
            cfg_reg.cluster_bytes     <= lfs_pkg::CLUSTER_BYTES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lfs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    lfs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    lfs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .target_clusters (cfg_reg.target_clusters),
        .job_valid       (qb_valid),
        .job_ready       (qb_ready),
        .job_data        (qb_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule
